@@ hdl/assert_macros.svh @@
// Assertion macros included by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/hkcp_pkg.sv @@
// Package: types, constants and character codes of the hex key command parser.
`timescale 1ns / 1ps
`default_nettype none
package hkcp_pkg;

    localparam logic [7:0] LOWEST_KEY_RST  = 8'h20;
    localparam logic [7:0] HIGHEST_KEY_RST = 8'hDA;

    localparam int unsigned CFG_ADDR_W = 3;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LX    = 8'h78;

    localparam logic EV_PRESS   = 1'b0;
    localparam logic EV_RELEASE = 1'b1;

    typedef enum logic [2:0] {
        PH_EMPTY  = 3'd0,
        PH_SPACE  = 3'd1,
        PH_SIGN   = 3'd2,
        PH_ZERO   = 3'd3,
        PH_ZEROX  = 3'd4,
        PH_DIGITS = 3'd5,
        PH_STOP   = 3'd6
    } phase_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] code;
        logic       last;
    } event_t;

    // Results of one byte: up to two events.
    typedef struct packed {
        logic [1:0] count;
        event_t     ev0;
        event_t     ev1;
    } result_t;

    typedef struct packed {
        logic [7:0] lowest_key;
        logic [7:0] highest_key;
    } key_range_t;

    // Hex digit decode: bit 4 set when the character is a hex digit.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, c[3:0]};
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            r = {1'b1, c[3:0] + 4'd9};
        return r;
    endfunction

endpackage
`default_nettype wire

@@ hdl/hex_key_command_parser_unit.sv @@
// Top level of the hex key command parser: input register, parser, result register, APB port.
// Path: a byte waits in the input register, is parsed and loaded into the result register.
// Throughput: one byte per cycle while events are taken; a byte with two events
//   holds the result register for two transfers, set by the single output port.
// Reset: rst_n clears the line state, empties both stages and sets the key range
//   to 0x20..0xDA; the block is ready as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module hex_key_command_parser_unit
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [7:0]                      rx_byte,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 event_kind,
    output logic      [7:0]                      key_code,
    output logic                                 last,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [hkcp_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready
);
    import hkcp_pkg::*;

    key_range_t key_range;
    result_t    result;
    event_t     head;
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       room;
    logic       advance;

    assign pready   = 1'b1;
    assign advance  = s1_valid_reg && room;
    assign in_ready = !s1_valid_reg || room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            s1_byte_reg <= rx_byte;
    end

    hkcp_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .key_range (key_range)
    );

    hkcp_parse u_parse
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .byte_in   (s1_byte_reg),
        .key_range (key_range),
        .result    (result)
    );

    hkcp_outq u_outq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .result    (result),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .head      (head),
        .room      (room)
    );

    assign event_kind = head.kind;
    assign key_code   = head.code;
    assign last       = head.last;

    `ASSERT_IMPL(a_release_code, clk, rst_n, out_valid && event_kind == EV_RELEASE, key_code == 8'd0, "release event carries a key code")
    `ASSERT_IMPL(a_no_overrun, clk, rst_n, in_valid && in_ready && s1_valid_reg, advance, "input stage overwritten")
    `ASSERT_NEXT(a_pair_first, clk, rst_n, advance && result.count == 2'd2, out_valid && !last, "first of two events marked last")
    `ASSERT_IMPL(a_load_room, clk, rst_n, advance, !out_valid || (out_ready && last), "result register reloaded while events pending")

endmodule
`default_nettype wire

@@ hdl/hkcp_cfg.sv @@
// APB-style configuration registers: key range limits.
`timescale 1ns / 1ps
`default_nettype none
module hkcp_cfg
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [hkcp_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output hkcp_pkg::key_range_t                 key_range
);
    import hkcp_pkg::*;

    logic [7:0] lowest_key_reg;
    logic [7:0] highest_key_reg;
    logic       wr_en;

    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lowest_key_reg  <= LOWEST_KEY_RST;
            highest_key_reg <= HIGHEST_KEY_RST;
        end
        else if (wr_en)
        begin
            if (paddr[2])
                highest_key_reg <= pwdata[7:0];
            else
                lowest_key_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        prdata = {24'd0, paddr[2] ? highest_key_reg : lowest_key_reg};
    end

    assign key_range.lowest_key  = lowest_key_reg;
    assign key_range.highest_key = highest_key_reg;

endmodule
`default_nettype wire

@@ hdl/hkcp_parse.sv @@
// Token and block parser: running line state and event generation per byte.
`timescale 1ns / 1ps
`default_nettype none
module hkcp_parse
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire logic [7:0]           byte_in,
    input  wire hkcp_pkg::key_range_t key_range,
    output hkcp_pkg::result_t         result
);
    import hkcp_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] value_reg, value_next;
    logic       ovf_reg, ovf_next;
    logic       neg_reg, neg_next;
    logic       pressed_reg, pressed_next;
    logic       early_reg, early_next;

    logic [4:0] hd;
    logic       is_eol, is_ws, end_tok, end_blk, take;
    logic       press, release_ev, tok_ok;
    logic       dig;

    assign hd     = hex_digit(byte_in);
    assign is_eol = (byte_in == CH_LF) || (byte_in == CH_CR);
    assign is_ws  = (byte_in == CH_SPACE) || (byte_in == CH_TAB)
                 || (byte_in == CH_VT) || (byte_in == CH_FF);
    assign end_blk = is_eol || (!early_reg && byte_in == CH_SEMI);
    assign end_tok = end_blk || (!early_reg && byte_in == CH_PLUS);
    assign take    = !is_eol && !early_reg && byte_in != CH_NUL
                  && byte_in != CH_SEMI && byte_in != CH_PLUS;

    assign tok_ok = (phase_reg != PH_EMPTY) && !ovf_reg && !(neg_reg && value_reg != 8'd0)
                 && value_reg >= key_range.lowest_key && value_reg <= key_range.highest_key;
    assign press      = end_tok && tok_ok;
    assign release_ev = end_blk && (pressed_reg || press);

    always_comb
    begin
        phase_next   = phase_reg;
        value_next   = value_reg;
        ovf_next     = ovf_reg;
        neg_next     = neg_reg;
        pressed_next = pressed_reg;
        early_next   = early_reg;
        dig          = 1'b0;

        if (is_eol)
            early_next = 1'b0;
        else if (!early_reg && byte_in == CH_NUL)
            early_next = 1'b1;

        if (end_tok)
        begin
            phase_next = PH_EMPTY;
            value_next = 8'd0;
            ovf_next   = 1'b0;
            neg_next   = 1'b0;
        end
        else if (take)
        begin
            case (phase_reg)
                PH_EMPTY, PH_SPACE:
                begin
                    if (is_ws)
                        phase_next = PH_SPACE;
                    else if (byte_in == CH_MINUS)
                    begin
                        neg_next   = 1'b1;
                        phase_next = PH_SIGN;
                    end
                    else if (byte_in == CH_ZERO)
                        phase_next = PH_ZERO;
                    else if (hd[4])
                        dig = 1'b1;
                    else
                        phase_next = PH_STOP;
                end
                PH_SIGN:
                begin
                    if (byte_in == CH_ZERO)
                        phase_next = PH_ZERO;
                    else if (hd[4])
                        dig = 1'b1;
                    else
                        phase_next = PH_STOP;
                end
                PH_ZERO:
                begin
                    if (byte_in == CH_LX || byte_in == CH_UX)
                        phase_next = PH_ZEROX;
                    else if (hd[4])
                        dig = 1'b1;
                    else
                        phase_next = PH_STOP;
                end
                PH_ZEROX, PH_DIGITS:
                begin
                    if (hd[4])
                        dig = 1'b1;
                    else
                        phase_next = PH_STOP;
                end
                default:
                    phase_next = PH_STOP;
            endcase

            if (dig)
            begin
                phase_next = PH_DIGITS;
                if (!ovf_reg)
                begin
                    if (value_reg[7:4] != 4'd0)
                        ovf_next = 1'b1;
                    else
                        value_next = {value_reg[3:0], hd[3:0]};
                end
            end
        end

        if (end_blk)
            pressed_next = 1'b0;
        else if (press)
            pressed_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_EMPTY;
            value_reg   <= 8'd0;
            ovf_reg     <= 1'b0;
            neg_reg     <= 1'b0;
            pressed_reg <= 1'b0;
            early_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            value_reg   <= value_next;
            ovf_reg     <= ovf_next;
            neg_reg     <= neg_next;
            pressed_reg <= pressed_next;
            early_reg   <= early_next;
        end
    end

    always_comb
    begin
        result.count = {1'b0, press} + {1'b0, release_ev};
        result.ev0.kind = press ? EV_PRESS : EV_RELEASE;
        result.ev0.code = press ? value_reg : 8'd0;
        result.ev0.last = !(press && release_ev);
        result.ev1.kind = EV_RELEASE;
        result.ev1.code = 8'd0;
        result.ev1.last = 1'b1;
    end

endmodule
`default_nettype wire

@@ hdl/hkcp_outq.sv @@
// Result register: holds up to two events of one byte and hands them out in order.
`timescale 1ns / 1ps
`default_nettype none
module hkcp_outq
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire hkcp_pkg::result_t  result,
    input  wire logic               out_ready,
    output logic                    out_valid,
    output hkcp_pkg::event_t        head,
    output logic                    room
);
    import hkcp_pkg::*;

    logic [1:0] count_reg, count_next;
    event_t     e0_reg, e0_next;
    event_t     e1_reg, e1_next;
    logic       pop;

    assign out_valid = count_reg != 2'd0;
    assign pop       = out_valid && out_ready;
    assign room      = (count_reg == 2'd0) || (count_reg == 2'd1 && out_ready);
    assign head      = e0_reg;

    always_comb
    begin
        count_next = count_reg;
        e0_next    = e0_reg;
        e1_next    = e1_reg;
        if (load)
        begin
            count_next = result.count;
            e0_next    = result.ev0;
            e1_next    = result.ev1;
        end
        else if (pop)
        begin
            count_next = count_reg - 2'd1;
            e0_next    = e1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        e0_reg <= e0_next;
        e1_reg <= e1_next;
    end

endmodule
`default_nettype wire
